FILE: sv/socks5_request_parser_defines.svh
// Assertion macros shared by the SOCKS5 request parser RTL.
`ifndef SOCKS5_REQUEST_PARSER_DEFINES_SVH
`define SOCKS5_REQUEST_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define S5RP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("s5rp: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define S5RP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("s5rp: next-cycle check failed");

`endif

FILE: sv/s5rp_pkg.sv
// Types and constants of the SOCKS5 request parser.
`default_nettype none

package s5rp_pkg;

	typedef enum logic [3:0] {
		PH_VERSION  = 4'd0,
		PH_CMD      = 4'd1,
		PH_RSV      = 4'd2,
		PH_ATYP     = 4'd3,
		PH_DOMLEN   = 4'd4,
		PH_ADDR     = 4'd5,
		PH_PORT     = 4'd6,
		PH_DONE     = 4'd7,
		PH_ERR_VER  = 4'd8,
		PH_ERR_ATYP = 4'd9
	} phase_t;

	typedef enum logic [1:0] {
		ST_BUSY     = 2'd0,
		ST_DONE     = 2'd1,
		ST_BAD_VER  = 2'd2,
		ST_BAD_ATYP = 2'd3
	} status_t;

	localparam logic [7:0] SOCKS_VERSION = 8'd5;
	localparam logic [7:0] ATYP_IPV4     = 8'd1;
	localparam logic [7:0] ATYP_DOMAIN   = 8'd3;
	localparam logic [7:0] ATYP_IPV6     = 8'd4;
	localparam logic [7:0] LEN_IPV4      = 8'd4;
	localparam logic [7:0] LEN_IPV6      = 8'd16;
	localparam logic [7:0] LEN_PORT      = 8'd2;

	typedef struct packed {
		phase_t      phase;
		logic [7:0]  cmd_hold;
		logic [7:0]  type_hold;
		logic [7:0]  bytes_read;
		logic [7:0]  bytes_total;
		logic [15:0] port_hold;
	} state_t;

	localparam state_t STATE_RESET = '{
		phase:       PH_VERSION,
		cmd_hold:    8'd0,
		type_hold:   8'd0,
		bytes_read:  8'd0,
		bytes_total: 8'd0,
		port_hold:   16'd0
	};

	typedef struct packed {
		status_t     status;
		logic [7:0]  command;
		logic [7:0]  addr_type;
		logic        addr_byte_valid;
		logic [7:0]  addr_byte;
		logic [7:0]  addr_index;
		logic [7:0]  addr_length;
		logic [15:0] dst_port;
	} result_t;

endpackage

`default_nettype wire

FILE: sv/s5rp_ifs.sv
// Valid/ready channel interfaces for request bytes and parse results.
`default_nettype none

interface s5rp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;

	modport source (output valid, output data_byte, output first_byte, input ready);
	modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

interface s5rp_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [7:0]  command;
	logic [7:0]  addr_type;
	logic        addr_byte_valid;
	logic [7:0]  addr_byte;
	logic [7:0]  addr_index;
	logic [7:0]  addr_length;
	logic [15:0] dst_port;

	modport source (
		output valid, output status, output command, output addr_type,
		output addr_byte_valid, output addr_byte, output addr_index,
		output addr_length, output dst_port, input ready
	);
	modport sink (
		input valid, input status, input command, input addr_type,
		input addr_byte_valid, input addr_byte, input addr_index,
		input addr_length, input dst_port, output ready
	);
endinterface

`default_nettype wire

FILE: sv/s5rp_step.sv
// Next-state and result logic for one request byte.
`default_nettype none

module s5rp_step (
	input  s5rp_pkg::state_t  cur,
	input  logic [7:0]        data_byte,
	input  logic              first_byte,
	output s5rp_pkg::state_t  nxt,
	output s5rp_pkg::result_t res
);
	import s5rp_pkg::*;

	state_t     st;
	logic [7:0] read_inc;
	logic       av;
	logic [7:0] ai;
	logic [7:0] al;
	status_t    status;

	always_comb begin
		st       = first_byte ? STATE_RESET : cur;
		nxt      = st;
		read_inc = st.bytes_read + 8'd1;
		av       = 1'b0;
		ai       = 8'd0;
		al       = 8'd0;

		unique case (st.phase)
			PH_VERSION: begin
				nxt.phase = (data_byte == SOCKS_VERSION) ? PH_CMD : PH_ERR_VER;
			end
			PH_CMD: begin
				nxt.cmd_hold = data_byte;
				nxt.phase    = PH_RSV;
			end
			PH_RSV: begin
				nxt.phase = PH_ATYP;
			end
			PH_ATYP: begin
				nxt.type_hold = data_byte;
				if (data_byte == ATYP_IPV4) begin
					nxt.bytes_read  = 8'd0;
					nxt.bytes_total = LEN_IPV4;
					nxt.phase       = PH_ADDR;
				end else if (data_byte == ATYP_IPV6) begin
					nxt.bytes_read  = 8'd0;
					nxt.bytes_total = LEN_IPV6;
					nxt.phase       = PH_ADDR;
				end else if (data_byte == ATYP_DOMAIN) begin
					nxt.phase = PH_DOMLEN;
				end else begin
					nxt.phase = PH_ERR_ATYP;
				end
			end
			PH_DOMLEN: begin
				nxt.bytes_read = 8'd0;
				if (data_byte == 8'd0) begin
					// empty domain: no address bytes, straight to the port
					nxt.bytes_total = LEN_PORT;
					nxt.port_hold   = 16'd0;
					nxt.phase       = PH_PORT;
				end else begin
					nxt.bytes_total = data_byte;
					nxt.phase       = PH_ADDR;
				end
			end
			PH_ADDR: begin
				av = 1'b1;
				ai = st.bytes_read;
				al = st.bytes_total;
				if (read_inc >= st.bytes_total) begin
					nxt.bytes_read  = 8'd0;
					nxt.bytes_total = LEN_PORT;
					nxt.port_hold   = 16'd0;
					nxt.phase       = PH_PORT;
				end else begin
					nxt.bytes_read = read_inc;
				end
			end
			PH_PORT: begin
				nxt.port_hold  = {st.port_hold[7:0], data_byte};
				nxt.bytes_read = read_inc;
				if (read_inc >= st.bytes_total) begin
					nxt.phase = PH_DONE;
				end
			end
			default: begin
				// done and error states hold until a restart
			end
		endcase

		case (nxt.phase)
			PH_DONE:     status = ST_DONE;
			PH_ERR_VER:  status = ST_BAD_VER;
			PH_ERR_ATYP: status = ST_BAD_ATYP;
			default:     status = ST_BUSY;
		endcase

		res.status          = status;
		res.command         = nxt.cmd_hold;
		res.addr_type       = nxt.type_hold;
		res.addr_byte_valid = av;
		res.addr_byte       = av ? data_byte : 8'd0;
		res.addr_index      = ai;
		res.addr_length     = al;
		res.dst_port        = (status == ST_DONE) ? nxt.port_hold : 16'd0;
	end

endmodule

`default_nettype wire

FILE: sv/socks5_request_parser.sv
// SOCKS5 connect-request parser top level: byte register, parse state, result register.
// Usage:
//   req carries one request byte per transaction (data_byte) with first_byte
//   marking the version byte of a new request; first_byte restarts parsing
//   from any state. rsp carries exactly one result per request byte: status,
//   held command and address type, the address byte with its index and the
//   address length when the byte belongs to the address, and the port once
//   status reads done.
//   A byte taken on req is held in the byte register, parsed from there, and its
//   result is offered on rsp from the result register, i.e. two registers deep.
//   Throughput: one byte per cycle, sustained while rsp is ready; the parse step
//   is a single pass through the phase decoder and the 8-bit index compare.
//   A stalled rsp holds its result; the byte register still drains into the
//   result register in the same cycle rsp is taken, so req.ready only drops
//   when both registers are full and rsp is not ready.
//   Reset (arst_n low) empties both registers and returns the parser to
//   expecting a version byte with all held fields cleared.
//   Done and the two error statuses stay until a first_byte restart.
`default_nettype none
`include "socks5_request_parser_defines.svh"

module socks5_request_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	s5rp_byte_if.sink            req,
	s5rp_result_if.source        rsp
);
	import s5rp_pkg::*;

	logic       valid_s1;
	logic [7:0] data_byte_s1;
	logic       first_byte_s1;
	state_t     state_q;
	state_t     state_nxt;
	result_t    res_nxt;
	logic       valid_s2;
	result_t    res_s2;
	logic       out_free;
	logic       adv_s1;

	assign out_free  = !valid_s2 || rsp.ready;
	assign adv_s1    = valid_s1 && out_free;
	assign req.ready = !valid_s1 || out_free;

	s5rp_step u_step (
		.cur        (state_q),
		.data_byte  (data_byte_s1),
		.first_byte (first_byte_s1),
		.nxt        (state_nxt),
		.res        (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= STATE_RESET;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (out_free) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			data_byte_s1  <= req.data_byte;
			first_byte_s1 <= req.first_byte;
		end
		if (adv_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign rsp.valid           = valid_s2;
	assign rsp.status          = res_s2.status;
	assign rsp.command         = res_s2.command;
	assign rsp.addr_type       = res_s2.addr_type;
	assign rsp.addr_byte_valid = res_s2.addr_byte_valid;
	assign rsp.addr_byte       = res_s2.addr_byte;
	assign rsp.addr_index      = res_s2.addr_index;
	assign rsp.addr_length     = res_s2.addr_length;
	assign rsp.dst_port        = res_s2.dst_port;

	// an address byte only ever comes out while the request is still in progress
	`S5RP_ASSERT_IMPLY(a_addr_busy, clk, arst_n,
		valid_s2 && res_s2.addr_byte_valid, res_s2.status == ST_BUSY)
	`S5RP_ASSERT_IMPLY(a_addr_index, clk, arst_n,
		valid_s2 && res_s2.addr_byte_valid, res_s2.addr_index < res_s2.addr_length)
	`S5RP_ASSERT_IMPLY(a_port_done, clk, arst_n,
		valid_s2 && (res_s2.dst_port != 16'd0), res_s2.status == ST_DONE)
	// a byte waiting on a stalled output must not be dropped
	`S5RP_ASSERT_NEXT(a_s1_hold, clk, arst_n,
		valid_s1 && !out_free, valid_s1)
	// terminal phases only leave on a restart
	`S5RP_ASSERT_NEXT(a_sticky, clk, arst_n,
		adv_s1 && !first_byte_s1 && (state_q.phase == PH_DONE ||
		state_q.phase == PH_ERR_VER || state_q.phase == PH_ERR_ATYP),
		$stable(state_q))

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for the SOCKS5 connect-request parser.
`timescale 1ns / 100ps

module tb;
	import s5rp_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_BYTES   = 170;
	localparam int HOLDOFF_CYCLES = 300;

	logic clk;
	logic arst_n;

	s5rp_byte_if   req_ch ();
	s5rp_result_if rsp_ch ();

	socks5_request_parser uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	state_t     parse_st;
	result_t    parse_results[$];
	result_t    want;
	logic [7:0] req_bytes[$];
	int         n_errors = 0;
	int         quiet_cycles = 0;
	int         rsp_holdoff_req = 0;
	int         stall_left = 0;
	int         counted_bytes = 0;
	bit         no_idle = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly short idles, a few long ones.
	function automatic int idle_len();
		if ($urandom_range(0, 99) < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Advances the parse state by one request byte and returns its result.
	function automatic result_t parse_byte(input logic [7:0] b, input logic f);
		result_t r;
		r = '0;
		if (f)
			parse_st = STATE_RESET;
		case (parse_st.phase)
			PH_VERSION: begin
				parse_st.phase = (b == SOCKS_VERSION) ? PH_CMD : PH_ERR_VER;
			end
			PH_CMD: begin
				parse_st.cmd_hold = b;
				parse_st.phase    = PH_RSV;
			end
			PH_RSV: begin
				parse_st.phase = PH_ATYP;
			end
			PH_ATYP: begin
				parse_st.type_hold = b;
				if (b == ATYP_IPV4 || b == ATYP_IPV6) begin
					parse_st.bytes_read  = 8'd0;
					parse_st.bytes_total = (b == ATYP_IPV4) ? LEN_IPV4 : LEN_IPV6;
					parse_st.phase       = PH_ADDR;
				end else if (b == ATYP_DOMAIN) begin
					parse_st.phase = PH_DOMLEN;
				end else begin
					parse_st.phase = PH_ERR_ATYP;
				end
			end
			PH_DOMLEN: begin
				parse_st.bytes_read = 8'd0;
				if (b == 8'd0) begin
					// empty domain: straight to the port
					parse_st.bytes_total = LEN_PORT;
					parse_st.port_hold   = 16'd0;
					parse_st.phase       = PH_PORT;
				end else begin
					parse_st.bytes_total = b;
					parse_st.phase       = PH_ADDR;
				end
			end
			PH_ADDR: begin
				r.addr_byte_valid   = 1'b1;
				r.addr_byte         = b;
				r.addr_index        = parse_st.bytes_read;
				r.addr_length       = parse_st.bytes_total;
				parse_st.bytes_read = parse_st.bytes_read + 8'd1;
				if (parse_st.bytes_read >= parse_st.bytes_total) begin
					parse_st.bytes_read  = 8'd0;
					parse_st.bytes_total = LEN_PORT;
					parse_st.port_hold   = 16'd0;
					parse_st.phase       = PH_PORT;
				end
			end
			PH_PORT: begin
				parse_st.port_hold  = {parse_st.port_hold[7:0], b};
				parse_st.bytes_read = parse_st.bytes_read + 8'd1;
				if (parse_st.bytes_read >= parse_st.bytes_total)
					parse_st.phase = PH_DONE;
			end
			default: ;
		endcase
		case (parse_st.phase)
			PH_DONE:     r.status = ST_DONE;
			PH_ERR_VER:  r.status = ST_BAD_VER;
			PH_ERR_ATYP: r.status = ST_BAD_ATYP;
			default:     r.status = ST_BUSY;
		endcase
		r.command   = parse_st.cmd_hold;
		r.addr_type = parse_st.type_hold;
		r.dst_port  = (r.status == ST_DONE) ? parse_st.port_hold : 16'd0;
		return r;
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_byte(input logic [7:0] b, input logic f);
		int gap;
		gap = (no_idle || $urandom_range(0, 99) < 70) ? 0 : idle_len();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.data_byte  <= b;
		req_ch.first_byte <= f;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		parse_results.push_back(parse_byte(b, f));
		@(negedge clk);
	endtask

	task automatic send_request();
		for (int i = 0; i < req_bytes.size(); i++)
			send_byte(req_bytes[i], i == 0);
	endtask

	// Well-formed request with random content, occasionally broken or cut short.
	task automatic build_request();
		int          kind;
		int          len;
		int          cut;
		logic [7:0]  atyp;
		logic [15:0] port;
		req_bytes.delete();
		req_bytes.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) :
			SOCKS_VERSION);
		req_bytes.push_back(8'($urandom_range(0, 255)));
		req_bytes.push_back(8'($urandom_range(0, 255)));
		kind = $urandom_range(0, 99);
		if (kind < 40) begin
			req_bytes.push_back(ATYP_IPV4);
			len = LEN_IPV4;
		end else if (kind < 60) begin
			req_bytes.push_back(ATYP_IPV6);
			len = LEN_IPV6;
		end else if (kind < 90) begin
			req_bytes.push_back(ATYP_DOMAIN);
			kind = $urandom_range(0, 99);
			if (kind < 10)
				len = 0;
			else if (kind < 13)
				len = $urandom_range(100, 255);
			else
				len = $urandom_range(1, 12);
			req_bytes.push_back(8'(len));
		end else begin
			do
				atyp = 8'($urandom_range(0, 255));
			while (atyp == ATYP_IPV4 || atyp == ATYP_IPV6 || atyp == ATYP_DOMAIN);
			req_bytes.push_back(atyp);
			len = 0;
		end
		for (int i = 0; i < len; i++)
			req_bytes.push_back(8'($urandom_range(0, 255)));
		port = 16'($urandom_range(0, 65535));
		req_bytes.push_back(port[15:8]);
		req_bytes.push_back(port[7:0]);
		if ($urandom_range(0, 9) == 0) begin
			cut = $urandom_range(1, req_bytes.size() - 1);
			while (req_bytes.size() > cut)
				void'(req_bytes.pop_back());
		end
	endtask

	task automatic test_errors();
		// version byte straight after reset, no restart flag
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		req_bytes = '{SOCKS_VERSION, 8'h80, 8'h00, 8'h00};
		send_request();
		send_byte(8'hFF, 1'b0);
	endtask

	task automatic test_restart_mid_request();
		req_bytes = '{SOCKS_VERSION, 8'h01};
		send_request();
	endtask

	task automatic test_empty_domain();
		req_bytes = '{SOCKS_VERSION, 8'hFF, 8'hFF, ATYP_DOMAIN, 8'h00, 8'hFF, 8'hFF};
		send_request();
	endtask

	task automatic test_ipv4();
		req_bytes = '{SOCKS_VERSION, 8'h00, 8'h00, ATYP_IPV4,
			8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00};
		send_request();
	endtask

	task automatic test_longest_domain();
		req_bytes = '{SOCKS_VERSION, 8'h01, 8'h00, ATYP_DOMAIN, 8'hFF};
		for (int i = 0; i < 255; i++)
			req_bytes.push_back(8'($urandom_range(0, 255)));
		req_bytes.push_back(8'h12);
		req_bytes.push_back(8'h34);
		send_request();
	endtask

	// Receiver holds off while the sender keeps offering bytes back to back.
	task automatic test_backpressure();
		rsp_holdoff_req = HOLDOFF_CYCLES;
		no_idle = 1'b1;
		req_bytes = '{SOCKS_VERSION, 8'h01, 8'h00, ATYP_IPV6};
		for (int i = 0; i < 16; i++)
			req_bytes.push_back(8'($urandom_range(0, 255)));
		req_bytes.push_back(8'h00);
		req_bytes.push_back(8'h50);
		send_request();
		no_idle = 1'b0;
	endtask

	task automatic test_drain_pause();
		build_request();
		send_request();
		req_ch.valid <= 1'b0;
		@(negedge clk);
		while (parse_results.size() != 0)
			@(negedge clk);
		build_request();
		send_request();
	endtask

	task automatic test_random();
		int n;
		counted_bytes = 0;
		while (counted_bytes < RANDOM_BYTES) begin
			if ($urandom_range(0, 99) < 15)
				no_idle = !no_idle;
			if ($urandom_range(0, 99) < 85) begin
				build_request();
				send_request();
				counted_bytes += req_bytes.size();
				// trailing bytes after a finished or failed request are ignored by the parser
				if ($urandom_range(0, 9) == 0) begin
					n = $urandom_range(1, 3);
					repeat (n)
						send_byte(8'($urandom_range(0, 255)), 1'b0);
				end
			end else begin
				n = $urandom_range(1, 4);
				repeat (n)
					send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				counted_bytes += n;
			end
		end
		no_idle = 1'b0;
	endtask

	// Result side: random stalls, plus the long hold-off on request.
	initial begin
		forever begin
			@(negedge clk);
			if (rsp_holdoff_req > 0) begin
				stall_left = rsp_holdoff_req;
				rsp_holdoff_req = 0;
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (no_idle || $urandom_range(0, 99) < 75) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				stall_left = idle_len() - 1;
				rsp_ch.ready <= 1'b0;
			end
		end
	end

	function automatic void check_field(input string name, input logic [15:0] exp_v,
		input logic [15:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
			n_errors++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (parse_results.size() == 0) begin
				$display("%0t: unexpected transaction, status %0d", $time, rsp_ch.status);
				n_errors++;
			end else begin
				want = parse_results.pop_front();
				check_field("status", 16'(want.status), 16'(rsp_ch.status));
				check_field("command", 16'(want.command), 16'(rsp_ch.command));
				check_field("addr_type", 16'(want.addr_type), 16'(rsp_ch.addr_type));
				check_field("addr_byte_valid", 16'(want.addr_byte_valid),
					16'(rsp_ch.addr_byte_valid));
				check_field("addr_byte", 16'(want.addr_byte), 16'(rsp_ch.addr_byte));
				check_field("addr_index", 16'(want.addr_index), 16'(rsp_ch.addr_index));
				check_field("addr_length", 16'(want.addr_length), 16'(rsp_ch.addr_length));
				check_field("dst_port", want.dst_port, rsp_ch.dst_port);
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog expired", $time);
				$display("tb NOT OK");
				$finish;
			end
		end
	end

	initial begin
		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.data_byte  = 8'd0;
		req_ch.first_byte = 1'b0;
		rsp_ch.ready      = 1'b0;
		parse_st          = STATE_RESET;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		test_errors();
		test_restart_mid_request();
		test_empty_domain();
		test_ipv4();
		test_longest_domain();
		test_backpressure();
		test_drain_pause();
		test_random();

		req_ch.valid <= 1'b0;
		while (parse_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (n_errors == 0 && parse_results.size() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
